// ===== hdl/lbpm_pkg.sv =====
// Shared types and constants of the buffer pool frame table.
package lbpm_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int PAGE_BITS = 20;
   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int COUNT_BITS = $clog2(NUM_FRAMES + 1);
   localparam int MAX_ACTIVE = (NUM_FRAMES < 16) ? NUM_FRAMES : 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CMD_PIN = 3'd0,
      CMD_UNPIN = 3'd1,
      CMD_DIRTY = 3'd2,
      CMD_FORCE = 3'd3,
      CMD_FLUSH = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_ALL_PINNED = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   // States of the back part.
   typedef enum logic [2:0] {
      B_IDLE, B_SCAN, B_FLUSH, B_EMIT
   } bstate_type;

   // Classified request from the front part.
   typedef struct packed {
      logic [2:0] cmd;
      logic [PAGE_BITS-1:0] page;
      logic found;
      logic [FRAME_BITS-1:0] frame;
      logic [COUNT_BITS-1:0] active;
   } job_type;

   // Snapshot of one frame used by the front scan.
   typedef struct packed {
      logic valid;
      logic [PAGE_BITS-1:0] page;
   } probe_type;

endpackage

// ===== hdl/lru_buffer_pool_manager.sv =====
// Top level of the buffer pool frame table.
//  channel | ports                                     | direction
//  request | push, full, req_cmd, req_page_num         | in
//  result  | empty, pop, rsp_*                         | out
//  config  | csr_valid, csr_ready, csr_frames_in_use   | in
// With n active frames, the front part looks the page up over the n frames and then hands
// the request to the back part, which registers the result.
// A pin miss adds a victim scan over the n frames; a flush sweeps n frames, one a cycle,
// and emits each write-back as the result register drains.
// Reset is synchronous and empties the pool; frames_in_use returns to 16.
// A full result register stalls the back part; full stays high until the back part has taken the request and is idle.
module lru_buffer_pool_manager (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [2:0] req_cmd,
   input  logic [19:0] req_page_num,
   output logic empty,
   input  logic pop,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_frame_index,
   output logic rsp_hit,
   output logic rsp_fetch_valid,
   output logic rsp_writeback_valid,
   output logic [19:0] rsp_writeback_page,
   output logic rsp_last,
   output logic [31:0] rsp_read_count,
   output logic [31:0] rsp_write_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_frames_in_use
);
   import lbpm_pkg::*;

   logic [4:0] fiu_ff;
   logic [COUNT_BITS-1:0] active;
   logic [FRAME_BITS-1:0] probe_idx;
   probe_type probe;
   logic back_busy, job_valid, job_take;
   job_type job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= 5'd16;
      end else if (csr_valid) begin
         fiu_ff <= csr_frames_in_use;
      end
   end

   // Clamp to 1..MAX_ACTIVE.
   always_comb begin
      if (fiu_ff == 5'd0) begin
         active = COUNT_BITS'(1);
      end else if (int'(fiu_ff) > MAX_ACTIVE) begin
         active = COUNT_BITS'(MAX_ACTIVE);
      end else begin
         active = COUNT_BITS'(fiu_ff);
      end
   end

   lbpm_front u_front (
      .clock(clock), .reset(reset), .req_push(push), .full(full),
      .req_cmd(req_cmd), .req_page_num(req_page_num), .active(active),
      .probe_idx(probe_idx), .probe(probe), .back_busy(back_busy),
      .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   lbpm_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_take(job_take), .busy(back_busy), .probe_idx(probe_idx), .probe(probe),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_status(rsp_status),
      .rsp_frame_index(rsp_frame_index), .rsp_hit(rsp_hit),
      .rsp_fetch_valid(rsp_fetch_valid), .rsp_writeback_valid(rsp_writeback_valid),
      .rsp_writeback_page(rsp_writeback_page), .rsp_last(rsp_last),
      .rsp_read_count(rsp_read_count), .rsp_write_count(rsp_write_count)
   );

endmodule

// ===== hdl/lbpm_front.sv =====
// Front part: accepts requests and looks the page up, one frame a cycle.
module lbpm_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic full,
   input  logic [2:0] req_cmd,
   input  logic [lbpm_pkg::PAGE_BITS-1:0] req_page_num,
   input  logic [lbpm_pkg::COUNT_BITS-1:0] active,
   output logic [lbpm_pkg::FRAME_BITS-1:0] probe_idx,
   input  lbpm_pkg::probe_type probe,
   input  logic back_busy,
   output logic job_valid,
   output lbpm_pkg::job_type job,
   input  logic job_take
);
   import lbpm_pkg::*;

   logic busy_ff, busy_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [FRAME_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] act_ff, act_in;
   logic found_ff, found_in;
   logic [FRAME_BITS-1:0] hit_ff, hit_in;
   logic done_ff, done_in;

   job_type q_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] rd_ff, wr_ff;
   logic [QUEUE_BITS:0] cnt_ff;
   logic push_q;
   logic accept;

   // One request is in flight at a time: the frame table changes under it.
   assign full = busy_ff || done_ff || back_busy || (cnt_ff != '0);
   assign accept = req_push && !full;
   assign probe_idx = idx_ff;
   assign job_valid = (cnt_ff != '0);
   assign job = q_ff[rd_ff];

   always_comb begin
      busy_in = busy_ff;
      cmd_in = cmd_ff;
      page_in = page_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      done_in = 1'b0;
      push_q = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         cmd_in = req_cmd;
         page_in = req_page_num;
         idx_in = '0;
         act_in = active;
         found_in = 1'b0;
         hit_in = '0;
      end else if (busy_ff) begin
         if (!found_ff && probe.valid && probe.page == page_ff) begin
            found_in = 1'b1;
            hit_in = idx_ff;
         end
         if (COUNT_BITS'(idx_ff) + COUNT_BITS'(1) >= act_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + FRAME_BITS'(1);
         end
      end
      if (done_ff) begin
         push_q = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (push_q) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (job_take) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + {{QUEUE_BITS{1'b0}}, push_q} - {{QUEUE_BITS{1'b0}}, job_take};
      end
      cmd_ff <= cmd_in;
      page_ff <= page_in;
      idx_ff <= idx_in;
      act_ff <= act_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      if (push_q) begin
         q_ff[wr_ff] <= '{cmd: cmd_ff, page: page_ff, found: found_ff, frame: hit_ff,
                          active: act_ff};
      end
   end

endmodule

// ===== hdl/lbpm_back.sv =====
// Back part: frame table, victim search, flush sweep and result register.
module lbpm_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  lbpm_pkg::job_type job,
   output logic job_take,
   output logic busy,
   input  logic [lbpm_pkg::FRAME_BITS-1:0] probe_idx,
   output lbpm_pkg::probe_type probe,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_frame_index,
   output logic rsp_hit,
   output logic rsp_fetch_valid,
   output logic rsp_writeback_valid,
   output logic [19:0] rsp_writeback_page,
   output logic rsp_last,
   output logic [31:0] rsp_read_count,
   output logic [31:0] rsp_write_count
);
   import lbpm_pkg::*;

   logic [PAGE_BITS-1:0] page_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, dirty_ff;
   logic [7:0] pin_ff [NUM_FRAMES];
   logic [31:0] stamp_ff [NUM_FRAMES];
   logic [31:0] clk_ff, reads_ff, writes_ff;

   bstate_type st_ff, st_in;
   job_type j_ff;
   logic [FRAME_BITS-1:0] i_ff, i_in;
   logic vic_ok_ff, vic_ok_in, vic_empty_ff, vic_empty_in;
   logic [FRAME_BITS-1:0] vic_ff, vic_in;
   logic any_ff, any_in;

   // Output register holding one result.
   logic o_full_ff;
   logic [1:0] o_stat_ff, o_stat_in;
   logic [3:0] o_frame_ff, o_frame_in;
   logic o_hit_ff, o_fetch_ff, o_wb_ff, o_last_ff;
   logic o_hit_in, o_fetch_in, o_wb_in, o_last_in;
   logic [19:0] o_page_ff, o_page_in;
   logic [31:0] o_rd_ff, o_wr_ff, o_rd_in, o_wr_in;
   logic o_load;

   logic o_free;
   logic last_idx;
   logic flush_sel;
   logic more_after;

   assign probe = '{valid: valid_ff[probe_idx], page: page_ff[probe_idx]};
   assign o_free = !o_full_ff || rsp_pop;
   assign rsp_empty = !o_full_ff;
   assign rsp_status = o_stat_ff;
   assign rsp_frame_index = o_frame_ff;
   assign rsp_hit = o_hit_ff;
   assign rsp_fetch_valid = o_fetch_ff;
   assign rsp_writeback_valid = o_wb_ff;
   assign rsp_writeback_page = o_page_ff;
   assign rsp_last = o_last_ff;
   assign rsp_read_count = o_rd_ff;
   assign rsp_write_count = o_wr_ff;
   // The frame table is final once the state machine is idle, so a waiting
   // result does not hold off the next lookup.
   assign busy = (st_ff != B_IDLE);
   assign job_take = job_valid && (st_ff == B_IDLE) && !o_full_ff;
   assign last_idx = (COUNT_BITS'(i_ff) + COUNT_BITS'(1) >= j_ff.active);
   assign flush_sel = valid_ff[i_ff] && pin_ff[i_ff] == 8'd0 && dirty_ff[i_ff];

   always_comb begin
      st_in = st_ff;
      i_in = i_ff;
      vic_ok_in = vic_ok_ff;
      vic_empty_in = vic_empty_ff;
      vic_in = vic_ff;
      any_in = any_ff;
      unique case (st_ff)
         B_IDLE: begin
            if (job_take) begin
               i_in = '0;
               vic_ok_in = 1'b0;
               vic_empty_in = 1'b0;
               vic_in = '0;
               any_in = 1'b0;
               if (job.cmd == CMD_PIN && !job.found) begin
                  st_in = B_SCAN;
               end else if (job.cmd == CMD_FLUSH) begin
                  st_in = B_FLUSH;
               end else begin
                  st_in = B_EMIT;
               end
            end
         end
         B_SCAN: begin
            // Empty frames win by lowest index; else the oldest unpinned stamp.
            if (!vic_empty_ff) begin
               if (!valid_ff[i_ff]) begin
                  vic_empty_in = 1'b1;
                  vic_ok_in = 1'b1;
                  vic_in = i_ff;
               end else if (pin_ff[i_ff] == 8'd0 &&
                            (!vic_ok_ff || stamp_ff[i_ff] < stamp_ff[vic_ff])) begin
                  vic_ok_in = 1'b1;
                  vic_in = i_ff;
               end
            end
            if (last_idx) begin
               st_in = B_EMIT;
            end else begin
               i_in = i_ff + FRAME_BITS'(1);
            end
         end
         B_FLUSH: begin
            if (o_free) begin
               if (flush_sel) begin
                  any_in = 1'b1;
               end
               if (last_idx) begin
                  st_in = (flush_sel || any_ff) ? B_IDLE : B_EMIT;
               end else begin
                  i_in = i_ff + FRAME_BITS'(1);
               end
            end
         end
         B_EMIT: begin
            if (o_free) begin
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   // Lookahead: does any frame after i_ff still need a flush?
   always_comb begin
      more_after = 1'b0;
      for (int k = 0; k < NUM_FRAMES; k++) begin
         if (k > int'(i_ff) && k < int'(j_ff.active) && valid_ff[k] &&
             pin_ff[k] == 8'd0 && dirty_ff[k]) begin
            more_after = 1'b1;
         end
      end
   end

   // Next result and the counters that go with it.
   always_comb begin
      o_load = 1'b0;
      o_stat_in = STAT_OK;
      o_frame_in = '0;
      o_hit_in = 1'b0;
      o_fetch_in = 1'b0;
      o_wb_in = 1'b0;
      o_page_in = '0;
      o_last_in = 1'b1;
      o_rd_in = reads_ff;
      o_wr_in = writes_ff;
      if (st_ff == B_FLUSH && o_free && flush_sel) begin
         o_load = 1'b1;
         o_frame_in = 4'(i_ff);
         o_wb_in = 1'b1;
         o_page_in = 20'(page_ff[i_ff]);
         o_last_in = !more_after;
         o_wr_in = writes_ff + 32'd1;
      end else if (st_ff == B_EMIT && o_free) begin
         o_load = 1'b1;
         priority case (1'b1)
            j_ff.cmd == CMD_PIN && j_ff.found: begin
               o_frame_in = 4'(j_ff.frame);
               o_hit_in = 1'b1;
            end
            j_ff.cmd == CMD_PIN: begin
               if (!vic_ok_ff) begin
                  o_stat_in = STAT_ALL_PINNED;
               end else begin
                  if (!vic_empty_ff && dirty_ff[vic_ff]) begin
                     o_wb_in = 1'b1;
                     o_page_in = 20'(page_ff[vic_ff]);
                     o_wr_in = writes_ff + 32'd1;
                  end
                  o_rd_in = reads_ff + 32'd1;
                  o_frame_in = 4'(vic_ff);
                  o_fetch_in = 1'b1;
               end
            end
            j_ff.cmd == CMD_UNPIN || j_ff.cmd == CMD_DIRTY: begin
               if (!j_ff.found) begin
                  o_stat_in = STAT_NOT_FOUND;
               end else begin
                  o_frame_in = 4'(j_ff.frame);
               end
            end
            j_ff.cmd == CMD_FORCE && j_ff.found: begin
               o_wr_in = writes_ff + 32'd1;
               o_frame_in = 4'(j_ff.frame);
               o_wb_in = 1'b1;
               o_page_in = 20'(page_ff[j_ff.frame]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int k = 0; k < NUM_FRAMES; k++) begin
            pin_ff[k] <= 8'd0;
         end
         clk_ff <= '0;
         reads_ff <= '0;
         writes_ff <= '0;
         o_full_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (o_load) begin
            o_full_ff <= 1'b1;
            reads_ff <= o_rd_in;
            writes_ff <= o_wr_in;
         end else if (rsp_pop) begin
            o_full_ff <= 1'b0;
         end
         if (st_ff == B_FLUSH && o_free && flush_sel) begin
            dirty_ff[i_ff] <= 1'b0;
         end
         if (st_ff == B_EMIT && o_free) begin
            priority case (1'b1)
               j_ff.cmd == CMD_PIN && j_ff.found: begin
                  if (pin_ff[j_ff.frame] != 8'd255) begin
                     pin_ff[j_ff.frame] <= pin_ff[j_ff.frame] + 8'd1;
                  end
                  stamp_ff[j_ff.frame] <= clk_ff;
                  clk_ff <= clk_ff + 32'd1;
               end
               j_ff.cmd == CMD_PIN: begin
                  if (vic_ok_ff) begin
                     valid_ff[vic_ff] <= 1'b1;
                     page_ff[vic_ff] <= j_ff.page;
                     pin_ff[vic_ff] <= 8'd1;
                     dirty_ff[vic_ff] <= 1'b0;
                     stamp_ff[vic_ff] <= clk_ff;
                     clk_ff <= clk_ff + 32'd1;
                  end
               end
               j_ff.cmd == CMD_UNPIN || j_ff.cmd == CMD_DIRTY: begin
                  if (j_ff.found) begin
                     if (j_ff.cmd == CMD_UNPIN) begin
                        if (pin_ff[j_ff.frame] != 8'd0) begin
                           pin_ff[j_ff.frame] <= pin_ff[j_ff.frame] - 8'd1;
                        end
                     end else begin
                        dirty_ff[j_ff.frame] <= 1'b1;
                     end
                  end
               end
               j_ff.cmd == CMD_FORCE && j_ff.found: begin
                  dirty_ff[j_ff.frame] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      if (o_load) begin
         o_stat_ff <= o_stat_in;
         o_frame_ff <= o_frame_in;
         o_hit_ff <= o_hit_in;
         o_fetch_ff <= o_fetch_in;
         o_wb_ff <= o_wb_in;
         o_page_ff <= o_page_in;
         o_last_ff <= o_last_in;
         o_rd_ff <= o_rd_in;
         o_wr_ff <= o_wr_in;
      end
      if (job_take) begin
         j_ff <= job;
      end
      i_ff <= i_in;
      vic_ok_ff <= vic_ok_in;
      vic_empty_ff <= vic_empty_in;
      vic_ff <= vic_in;
      any_ff <= any_in;
   end

endmodule
